@@ sv/bn_inf_pkg.sv @@
`default_nettype none
package bn_inf_pkg;

  localparam int DATA_W       = 16;
  localparam int FRAC_BITS    = 8;
  localparam int MAX_CHANNELS = 64;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int NCH_W        = 7;
  localparam int APPLY_W      = 13;
  localparam int REP_W        = 12;
  localparam int MAX_APPLY    = 4096;

  // Square root of variance * 2^FRAC_BITS, two radicand bits per step.
  localparam int RAD_W      = DATA_W + FRAC_BITS;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int ROOT_REM_W = ROOT_W + 2;
  localparam int ROOT_STEPS = ROOT_W;

  // Restoring division of |diff| * 2^FRAC_BITS by root + epsilon.
  localparam int DIFF_W     = DATA_W + 1;
  localparam int DVSR_W     = DATA_W + 1;
  localparam int DVD_W      = DIFF_W + FRAC_BITS;
  localparam int DIV_STEPS  = DVD_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [DATA_W-1:0] SAT_HI = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_LO = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DATA = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_APPLY_COUNT  = 2'd0,
    CFG_NUM_CHANNELS = 2'd1,
    CFG_EPSILON      = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SETUP,
    ST_ROOT,
    ST_DIVSET,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic root_init;
    logic root_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic step_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ sv/batch_norm_inference_top.sv @@
// Batch normalization for inference on a stream of signed Q8.8 words. Load words
// (op 0) write one channel's mean and variance. A data word in range of the
// vector passes, from acceptance until its result sits in the output register,
// through one table read, twelve square-root steps and twenty-five
// restoring-division steps, one bit each, plus setup states. The input is
// stalled meanwhile; the next word is accepted in the cycle after the result
// register loads, even while that result still waits to be taken. Samples
// beyond the vector produce no result. Configuration writes are always ready
// and must be made only while the block is idle.
// Reading a table entry that was never loaded gives an undefined result.
`default_nettype none
module batch_norm_inference_top (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic                                     in_op,
  input  wire logic        [bn_inf_pkg::CH_W-1:0]       in_entry_index,
  input  wire logic signed [bn_inf_pkg::DATA_W-1:0]     in_mean_value,
  input  wire logic        [bn_inf_pkg::DATA_W-1:0]     in_variance_value,
  input  wire logic signed [bn_inf_pkg::DATA_W-1:0]     in_sample,
  input  wire logic                                     in_last,
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic signed      [bn_inf_pkg::DATA_W-1:0]     out_norm_value,
  output logic             [bn_inf_pkg::CH_W-1:0]       out_channel,
  output logic                                          out_end_of_vector,
  output logic                                          out_zero_divisor,
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic        [bn_inf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [bn_inf_pkg::CFG_DATA_W-1:0] cfg_data
);

  bn_inf_pkg::cmd_t    cmd;
  bn_inf_pkg::status_t status;
  logic                cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  bn_inf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  bn_inf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_op             (in_op),
    .in_entry_index    (in_entry_index),
    .in_mean_value     (in_mean_value),
    .in_variance_value (in_variance_value),
    .in_sample         (in_sample),
    .in_last           (in_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_norm_value    (out_norm_value),
    .out_channel       (out_channel),
    .out_end_of_vector (out_end_of_vector),
    .out_zero_divisor  (out_zero_divisor)
  );

endmodule
`default_nettype wire

@@ sv/bn_inf_ctrl.sv @@
`default_nettype none
module bn_inf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_op,
  input  wire bn_inf_pkg::status_t status,
  output logic                     in_stall,
  output bn_inf_pkg::cmd_t         cmd
);

  bn_inf_pkg::state_t state_r, state_nxt;
  logic accept;

  assign accept = in_valid && (state_r == bn_inf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bn_inf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bn_inf_pkg::ST_IDLE: begin
        if (accept && (in_op == bn_inf_pkg::OP_DATA) && status.in_range) begin
          state_nxt = bn_inf_pkg::ST_READ;
        end
      end
      bn_inf_pkg::ST_READ:   state_nxt = bn_inf_pkg::ST_SETUP;
      bn_inf_pkg::ST_SETUP:  state_nxt = bn_inf_pkg::ST_ROOT;
      bn_inf_pkg::ST_ROOT: begin
        if (status.step_last) begin
          state_nxt = bn_inf_pkg::ST_DIVSET;
        end
      end
      bn_inf_pkg::ST_DIVSET: state_nxt = bn_inf_pkg::ST_DIV;
      bn_inf_pkg::ST_DIV: begin
        if (status.step_last) begin
          state_nxt = bn_inf_pkg::ST_FINISH;
        end
      end
      bn_inf_pkg::ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = bn_inf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bn_inf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    in_stall   = (state_r != bn_inf_pkg::ST_IDLE);
    unique case (state_r)
      bn_inf_pkg::ST_READ:   cmd.read      = 1'b1;
      bn_inf_pkg::ST_SETUP:  cmd.root_init = 1'b1;
      bn_inf_pkg::ST_ROOT:   cmd.root_step = 1'b1;
      bn_inf_pkg::ST_DIVSET: cmd.div_init  = 1'b1;
      bn_inf_pkg::ST_DIV:    cmd.div_step  = 1'b1;
      bn_inf_pkg::ST_FINISH: cmd.out_load  = status.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/bn_inf_dp.sv @@
`default_nettype none
module bn_inf_dp (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire bn_inf_pkg::cmd_t                         cmd,
  output bn_inf_pkg::status_t                           status,
  input  wire logic                                     in_op,
  input  wire logic        [bn_inf_pkg::CH_W-1:0]       in_entry_index,
  input  wire logic signed [bn_inf_pkg::DATA_W-1:0]     in_mean_value,
  input  wire logic        [bn_inf_pkg::DATA_W-1:0]     in_variance_value,
  input  wire logic signed [bn_inf_pkg::DATA_W-1:0]     in_sample,
  input  wire logic                                     in_last,
  input  wire logic                                     cfg_we,
  input  wire logic        [bn_inf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [bn_inf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                                     out_stall,
  output logic                                          out_valid,
  output logic signed      [bn_inf_pkg::DATA_W-1:0]     out_norm_value,
  output logic             [bn_inf_pkg::CH_W-1:0]       out_channel,
  output logic                                          out_end_of_vector,
  output logic                                          out_zero_divisor
);

  localparam int DW  = bn_inf_pkg::DATA_W;
  localparam int CW  = bn_inf_pkg::CH_W;
  localparam int AW  = bn_inf_pkg::APPLY_W;
  localparam int NW  = bn_inf_pkg::NCH_W;
  localparam int RW  = bn_inf_pkg::REP_W;
  localparam int QW  = bn_inf_pkg::ROOT_W;
  localparam int MW  = bn_inf_pkg::ROOT_REM_W;
  localparam int XW  = bn_inf_pkg::RAD_W;
  localparam int FW  = bn_inf_pkg::DIFF_W;
  localparam int VW  = bn_inf_pkg::DVSR_W;
  localparam int DVW = bn_inf_pkg::DVD_W;
  localparam int SW  = bn_inf_pkg::STEP_W;
  localparam int FB  = bn_inf_pkg::FRAC_BITS;

  localparam logic [AW-1:0] APPLY_MAX = AW'(bn_inf_pkg::MAX_APPLY);
  localparam logic [NW-1:0] CHAN_MAX  = NW'(bn_inf_pkg::MAX_CHANNELS);

  // Configuration registers.
  logic [AW-1:0] apply_r;
  logic [NW-1:0] nch_r;
  logic [DW-1:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apply_r <= AW'(1);
      nch_r   <= NW'(1);
      eps_r   <= DW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bn_inf_pkg::CFG_APPLY_COUNT:  apply_r <= cfg_data[AW-1:0];
        bn_inf_pkg::CFG_NUM_CHANNELS: nch_r   <= cfg_data[NW-1:0];
        bn_inf_pkg::CFG_EPSILON:      eps_r   <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // Position within the vector.
  logic [RW-1:0] rep_r, rep_nxt;
  logic [NW-1:0] chc_r, chc_nxt;
  logic [AW-1:0] eff_apply;
  logic [NW-1:0] eff_ch;
  logic          in_range, rep_wrap, data_acc;

  always_comb begin
    if (apply_r == '0) begin
      eff_apply = AW'(1);
    end else if (apply_r > APPLY_MAX) begin
      eff_apply = APPLY_MAX;
    end else begin
      eff_apply = apply_r;
    end
    if (nch_r == '0) begin
      eff_ch = NW'(1);
    end else if (nch_r > CHAN_MAX) begin
      eff_ch = CHAN_MAX;
    end else begin
      eff_ch = nch_r;
    end
  end

  assign in_range = (chc_r < eff_ch);
  assign rep_wrap = (({1'b0, rep_r} + AW'(1)) >= eff_apply);
  assign data_acc = cmd.accept && (in_op == bn_inf_pkg::OP_DATA);

  always_comb begin
    rep_nxt = rep_r;
    chc_nxt = chc_r;
    if (data_acc) begin
      if (in_last) begin
        rep_nxt = '0;
        chc_nxt = '0;
      end else if (in_range) begin
        if (rep_wrap) begin
          rep_nxt = '0;
          chc_nxt = chc_r + NW'(1);
        end else begin
          rep_nxt = rep_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r <= '0;
      chc_r <= '0;
    end else begin
      rep_r <= rep_nxt;
      chc_r <= chc_nxt;
    end
  end

  // Per-channel tables.
  logic signed [DW-1:0] mean_mem [bn_inf_pkg::MAX_CHANNELS];
  logic        [DW-1:0] var_mem  [bn_inf_pkg::MAX_CHANNELS];
  logic signed [DW-1:0] mean_rd_r;
  logic        [DW-1:0] var_rd_r;

  logic signed [DW-1:0] sample_r;
  logic [CW-1:0]        ch_r;
  logic                 last_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_op == bn_inf_pkg::OP_LOAD)) begin
      mean_mem[in_entry_index] <= in_mean_value;
      var_mem[in_entry_index]  <= in_variance_value;
    end
    if (cmd.read) begin
      mean_rd_r <= mean_mem[ch_r];
      var_rd_r  <= var_mem[ch_r];
    end
    if (data_acc) begin
      sample_r <= in_sample;
      ch_r     <= chc_r[CW-1:0];
      last_r   <= in_last;
    end
  end

  // Iterative square root and restoring divider share one step counter.
  logic [XW-1:0]        rad_r;
  logic [MW-1:0]        rrem_r;
  logic [QW-1:0]        root_r;
  logic signed [FW-1:0] diff_r;
  logic [VW-1:0]        dvsr_r;
  logic [DVW-1:0]       dvd_r;
  logic [VW-1:0]        drem_r;
  logic [SW-1:0]        step_r;

  logic [MW+1:0] r_shift, r_trial;
  logic          r_ge;
  logic [VW:0]   d_shift;
  logic          d_ge;
  logic [FW-1:0] mag;

  assign r_shift = {rrem_r, rad_r[XW-1 -: 2]};
  assign r_trial = (MW+2)'({root_r, 2'b01});
  assign r_ge    = (r_shift >= r_trial);
  assign d_shift = {drem_r, dvd_r[DVW-1]};
  assign d_ge    = (d_shift >= {1'b0, dvsr_r});
  assign mag     = diff_r[FW-1] ? FW'(-diff_r) : FW'(diff_r);

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad_r  <= {var_rd_r, {FB{1'b0}}};
      rrem_r <= '0;
      root_r <= '0;
      step_r <= SW'(bn_inf_pkg::ROOT_STEPS - 1);
      diff_r <= FW'(sample_r) - FW'(mean_rd_r);
    end
    if (cmd.root_step) begin
      rad_r  <= {rad_r[XW-3:0], 2'b00};
      step_r <= step_r - SW'(1);
      if (r_ge) begin
        rrem_r <= MW'(r_shift - r_trial);
        root_r <= {root_r[QW-2:0], 1'b1};
      end else begin
        rrem_r <= r_shift[MW-1:0];
        root_r <= {root_r[QW-2:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      dvsr_r <= VW'(root_r) + VW'(eps_r);
      dvd_r  <= {mag, {FB{1'b0}}};
      drem_r <= '0;
      step_r <= SW'(bn_inf_pkg::DIV_STEPS - 1);
    end
    // The quotient bits shift into the dividend register from the bottom.
    if (cmd.div_step) begin
      step_r <= step_r - SW'(1);
      dvd_r  <= {dvd_r[DVW-2:0], d_ge};
      if (d_ge) begin
        drem_r <= VW'(d_shift - {1'b0, dvsr_r});
      end else begin
        drem_r <= d_shift[VW-1:0];
      end
    end
  end

  // Saturation and sign.
  logic signed [DW-1:0] norm;
  logic                 zdiv;

  always_comb begin
    zdiv = (dvsr_r == '0);
    if (zdiv) begin
      if (diff_r == '0) begin
        norm = '0;
      end else if (diff_r[FW-1]) begin
        norm = bn_inf_pkg::SAT_LO;
      end else begin
        norm = bn_inf_pkg::SAT_HI;
      end
    end else if (diff_r[FW-1]) begin
      if (dvd_r > DVW'({1'b1, {(DW-1){1'b0}}})) begin
        norm = bn_inf_pkg::SAT_LO;
      end else begin
        norm = DW'(-dvd_r[DW-1:0]);
      end
    end else if (dvd_r > DVW'(bn_inf_pkg::SAT_HI)) begin
      norm = bn_inf_pkg::SAT_HI;
    end else begin
      norm = dvd_r[DW-1:0];
    end
  end

  // Result register; it frees the input side while a word waits here.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_norm_value    <= norm;
      out_channel       <= ch_r;
      out_end_of_vector <= last_r;
      out_zero_divisor  <= zdiv;
    end
  end

  assign out_valid        = out_valid_r;
  assign status.in_range  = in_range;
  assign status.step_last = (step_r == '0);
  assign status.out_free  = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

@@ sv/bn_inf_checker.sv @@
`default_nettype none
module bn_inf_checker (
  input wire logic                                     clk,
  input wire logic                                     rst_n,
  input wire logic                                     in_stall,
  input wire logic                                     out_valid,
  input wire logic                                     out_stall,
  input wire logic signed [bn_inf_pkg::DATA_W-1:0]     out_norm_value,
  input wire logic        [bn_inf_pkg::CH_W-1:0]       out_channel,
  input wire logic                                     out_end_of_vector,
  input wire logic                                     out_zero_divisor
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_norm_value)
      && $stable(out_channel) && $stable(out_end_of_vector)
      && $stable(out_zero_divisor))
    else $error("result word changed while stalled");

  // A zero divisor only ever yields a saturated value or zero.
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_divisor |->
      (out_norm_value == bn_inf_pkg::SAT_HI) || (out_norm_value == bn_inf_pkg::SAT_LO)
      || (out_norm_value == '0))
    else $error("zero divisor with unsaturated value");

  // A new result comes only out of a computation that held the input off.
  a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a busy period");

endmodule

bind batch_norm_inference_top bn_inf_checker u_bn_inf_checker (.*);
`default_nettype wire
